[rtl/core/obbqt_pkg.sv]
// Shared types, constants and control bundles for the order book best-quote tracker.
// Used by every file under rtl/core; depends on nothing.
package obbqt_pkg;

  localparam int unsigned TableSlots = 4096;
  localparam int unsigned BookLevels = 64;
  localparam logic [31:0] QtyMax     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               mode;
    logic [63:0]        ord_ref;
    logic               side;
    logic signed [63:0] price;
    logic [31:0]        qty;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic signed [63:0] bid_px;
    logic [31:0]        bid_sz;
    logic signed [63:0] ask_px;
    logic [31:0]        ask_sz;
  } out_item_t;

  typedef struct packed {
    logic               used;
    logic [63:0]        key;
    logic               side;
    logic signed [63:0] price;
    logic [31:0]        qty;
  } slot_t;

  typedef struct packed {
    logic signed [63:0] price;
    logic [31:0]        qty;
  } level_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_PUT_RD,
    S_PUT_CHK,
    S_LVL_RD,
    S_LVL_CHK,
    S_INS_CHK,
    S_INS_MV,
    S_FIND_RD,
    S_FIND_CHK,
    S_RED_RD,
    S_RED_CHK,
    S_REM_CHK,
    S_REM_MV,
    S_ERASE,
    S_WALK_RD,
    S_WALK_CHK,
    S_RE_HOME,
    S_RE_RD,
    S_RE_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic cap_in;
    logic clr_wr;
    logic probe_home;
    logic probe_next;
    logic slot_rd_p;
    logic slot_rd_nx;
    logic slot_wr_put;
    logic slot_wr_free_p;
    logic slot_wr_free_nx;
    logic take_found;
    logic take_lift;
    logic nx_init;
    logic nx_next;
    logic set_fail;
    logic lvl_init;
    logic lvl_next;
    logic lvl_rd_j;
    logic lvl_rd_km1;
    logic lvl_rd_kp1;
    logic lvl_wr_merge;
    logic lvl_wr_reduce;
    logic lvl_wr_move;
    logic lvl_wr_ins;
    logic k_from_n;
    logic k_from_j;
    logic k_dec;
    logic k_inc;
    logic cnt_inc;
    logic cnt_dec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic used;
    logic key_eq;
    logic probe_last;
    logic steps_done;
    logic j_end;
    logic book_full;
    logic lvl_eq;
    logic lvl_better;
    logic lvl_le;
    logic k_at_j;
    logic k_end;
    logic clr_last;
    logic out_busy;
  } sts_t;

endpackage

[rtl/core/order_book_best_quote_tracker_top.sv]
// Order book best-quote tracker: tracks bid and ask price levels from add/cancel items.
// Top level; instantiates obbqt_ctrl and obbqt_dp, uses obbqt_pkg.
//
// Input channel in_valid_i/in_stall_o carries one add or cancel item; output channel
// out_valid_o/out_stall_i returns one result item (status, best bid, best ask) per item.
// One item is worked at a time. Each hash probe reads and checks a slot, each level
// compared is read and checked, and each level shifted is read and written; the level
// scan is then closed or a new level written. A cancel also frees the slot, then
// re-inserts each cluster entry by probing and finds the cluster end.
// Time is set by the slot and level memories with registered reads. The next item is
// accepted in the cycle after the result is loaded.
// After reset the block sweeps the slot table once, with in_stall_o
// high. The result sits in an output register; the next item is accepted while it
// waits, and only its completion waits while out_stall_i is high.
// TABLE_SLOTS must be a power of two.
module order_book_best_quote_tracker_top #(
  parameter int unsigned TABLE_SLOTS = obbqt_pkg::TableSlots,
  parameter int unsigned BOOK_LEVELS = obbqt_pkg::BookLevels
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  obbqt_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output obbqt_pkg::out_item_t out_item_o
);

  obbqt_pkg::cmd_t cmd;
  obbqt_pkg::sts_t sts;

  obbqt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  obbqt_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .BOOK_LEVELS (BOOK_LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[rtl/core/obbqt_ctrl.sv]
// Sequencer for the order book best-quote tracker.
// Drives obbqt_pkg::cmd_t into the datapath from obbqt_pkg::sts_t; uses obbqt_pkg.
module obbqt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  obbqt_pkg::sts_t  sts_i,
  output obbqt_pkg::cmd_t  cmd_o
);

  obbqt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= obbqt_pkg::S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      obbqt_pkg::S_CLR:      if (sts_i.clr_last) state_d = obbqt_pkg::S_IDLE;
      obbqt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.mode ? obbqt_pkg::S_FIND_RD : obbqt_pkg::S_PUT_RD;
        end
      end
      obbqt_pkg::S_PUT_RD:   state_d = obbqt_pkg::S_PUT_CHK;
      obbqt_pkg::S_PUT_CHK: begin
        if (!sts_i.used || sts_i.key_eq) state_d = obbqt_pkg::S_LVL_RD;
        else if (sts_i.probe_last)       state_d = obbqt_pkg::S_DONE;
        else                             state_d = obbqt_pkg::S_PUT_RD;
      end
      obbqt_pkg::S_LVL_RD: begin
        if (!sts_i.j_end)         state_d = obbqt_pkg::S_LVL_CHK;
        else if (sts_i.book_full) state_d = obbqt_pkg::S_DONE;
        else                      state_d = obbqt_pkg::S_INS_CHK;
      end
      obbqt_pkg::S_LVL_CHK: begin
        if (sts_i.lvl_eq)          state_d = obbqt_pkg::S_DONE;
        else if (sts_i.lvl_better) begin
          state_d = sts_i.book_full ? obbqt_pkg::S_DONE : obbqt_pkg::S_INS_CHK;
        end else                   state_d = obbqt_pkg::S_LVL_RD;
      end
      obbqt_pkg::S_INS_CHK:  state_d = sts_i.k_at_j ? obbqt_pkg::S_DONE : obbqt_pkg::S_INS_MV;
      obbqt_pkg::S_INS_MV:   state_d = obbqt_pkg::S_INS_CHK;
      obbqt_pkg::S_FIND_RD:  state_d = obbqt_pkg::S_FIND_CHK;
      obbqt_pkg::S_FIND_CHK: begin
        if (!sts_i.used)           state_d = obbqt_pkg::S_DONE;
        else if (sts_i.key_eq)     state_d = obbqt_pkg::S_RED_RD;
        else if (sts_i.probe_last) state_d = obbqt_pkg::S_DONE;
        else                       state_d = obbqt_pkg::S_FIND_RD;
      end
      obbqt_pkg::S_RED_RD:   state_d = sts_i.j_end ? obbqt_pkg::S_ERASE : obbqt_pkg::S_RED_CHK;
      obbqt_pkg::S_RED_CHK: begin
        if (sts_i.lvl_eq) begin
          state_d = sts_i.lvl_le ? obbqt_pkg::S_REM_CHK : obbqt_pkg::S_ERASE;
        end else begin
          state_d = obbqt_pkg::S_RED_RD;
        end
      end
      obbqt_pkg::S_REM_CHK:  state_d = sts_i.k_end ? obbqt_pkg::S_ERASE : obbqt_pkg::S_REM_MV;
      obbqt_pkg::S_REM_MV:   state_d = obbqt_pkg::S_REM_CHK;
      obbqt_pkg::S_ERASE:    state_d = obbqt_pkg::S_WALK_RD;
      obbqt_pkg::S_WALK_RD:  state_d = sts_i.steps_done ? obbqt_pkg::S_DONE : obbqt_pkg::S_WALK_CHK;
      obbqt_pkg::S_WALK_CHK: state_d = sts_i.used ? obbqt_pkg::S_RE_HOME : obbqt_pkg::S_DONE;
      obbqt_pkg::S_RE_HOME:  state_d = obbqt_pkg::S_RE_RD;
      obbqt_pkg::S_RE_RD:    state_d = obbqt_pkg::S_RE_CHK;
      obbqt_pkg::S_RE_CHK: begin
        state_d = (!sts_i.used || sts_i.key_eq) ? obbqt_pkg::S_WALK_RD : obbqt_pkg::S_RE_RD;
      end
      obbqt_pkg::S_DONE:     if (!sts_i.out_busy) state_d = obbqt_pkg::S_IDLE;
      default:               state_d = obbqt_pkg::S_CLR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      obbqt_pkg::S_CLR:  cmd_o.clr_wr = 1'b1;
      obbqt_pkg::S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.cap_in = in_valid_i;
      end
      obbqt_pkg::S_PUT_RD: cmd_o.slot_rd_p = 1'b1;
      obbqt_pkg::S_PUT_CHK: begin
        if (!sts_i.used || sts_i.key_eq) begin
          cmd_o.slot_wr_put = 1'b1;
          cmd_o.lvl_init    = 1'b1;
        end else if (sts_i.probe_last) begin
          cmd_o.set_fail = 1'b1;
        end else begin
          cmd_o.probe_next = 1'b1;
        end
      end
      obbqt_pkg::S_LVL_RD: begin
        if (!sts_i.j_end)         cmd_o.lvl_rd_j = 1'b1;
        else if (!sts_i.book_full) cmd_o.k_from_n = 1'b1;
      end
      obbqt_pkg::S_LVL_CHK: begin
        if (sts_i.lvl_eq) begin
          cmd_o.lvl_wr_merge = 1'b1;
        end else if (sts_i.lvl_better) begin
          cmd_o.k_from_n = !sts_i.book_full;
        end else begin
          cmd_o.lvl_next = 1'b1;
        end
      end
      obbqt_pkg::S_INS_CHK: begin
        if (sts_i.k_at_j) begin
          cmd_o.lvl_wr_ins = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
        end else begin
          cmd_o.lvl_rd_km1 = 1'b1;
        end
      end
      obbqt_pkg::S_INS_MV: begin
        cmd_o.lvl_wr_move = 1'b1;
        cmd_o.k_dec       = 1'b1;
      end
      obbqt_pkg::S_FIND_RD: cmd_o.slot_rd_p = 1'b1;
      obbqt_pkg::S_FIND_CHK: begin
        if (!sts_i.used) begin
          cmd_o.set_fail = 1'b1;
        end else if (sts_i.key_eq) begin
          cmd_o.take_found = 1'b1;
          cmd_o.lvl_init   = 1'b1;
        end else if (sts_i.probe_last) begin
          cmd_o.set_fail = 1'b1;
        end else begin
          cmd_o.probe_next = 1'b1;
        end
      end
      obbqt_pkg::S_RED_RD: cmd_o.lvl_rd_j = !sts_i.j_end;
      obbqt_pkg::S_RED_CHK: begin
        if (sts_i.lvl_eq) begin
          if (sts_i.lvl_le) cmd_o.k_from_j = 1'b1;
          else              cmd_o.lvl_wr_reduce = 1'b1;
        end else begin
          cmd_o.lvl_next = 1'b1;
        end
      end
      obbqt_pkg::S_REM_CHK: begin
        if (sts_i.k_end) cmd_o.cnt_dec = 1'b1;
        else             cmd_o.lvl_rd_kp1 = 1'b1;
      end
      obbqt_pkg::S_REM_MV: begin
        cmd_o.lvl_wr_move = 1'b1;
        cmd_o.k_inc       = 1'b1;
      end
      obbqt_pkg::S_ERASE: begin
        cmd_o.slot_wr_free_p = 1'b1;
        cmd_o.nx_init        = 1'b1;
      end
      obbqt_pkg::S_WALK_RD: cmd_o.slot_rd_nx = !sts_i.steps_done;
      obbqt_pkg::S_WALK_CHK: begin
        if (sts_i.used) begin
          cmd_o.take_lift       = 1'b1;
          cmd_o.slot_wr_free_nx = 1'b1;
        end
      end
      obbqt_pkg::S_RE_HOME: cmd_o.probe_home = 1'b1;
      obbqt_pkg::S_RE_RD:   cmd_o.slot_rd_p  = 1'b1;
      obbqt_pkg::S_RE_CHK: begin
        if (!sts_i.used || sts_i.key_eq) begin
          cmd_o.slot_wr_put = 1'b1;
          cmd_o.nx_next     = 1'b1;
        end else begin
          cmd_o.probe_next = 1'b1;
        end
      end
      obbqt_pkg::S_DONE: cmd_o.out_load = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

[rtl/core/obbqt_dp.sv]
// Datapath: order hash table memory, two level books, pointers and result register.
// Commanded by obbqt_ctrl; uses obbqt_pkg types.
module obbqt_dp #(
  parameter int unsigned TABLE_SLOTS = obbqt_pkg::TableSlots,
  parameter int unsigned BOOK_LEVELS = obbqt_pkg::BookLevels
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  obbqt_pkg::in_item_t  in_item_i,
  input  obbqt_pkg::cmd_t      cmd_i,
  output obbqt_pkg::sts_t      sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output obbqt_pkg::out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam int unsigned LW = $clog2(BOOK_LEVELS);
  localparam int unsigned CW = $clog2(BOOK_LEVELS + 1);

  obbqt_pkg::slot_t  slot_mem [2**AW];
  obbqt_pkg::level_t lvl_mem  [2**(LW+1)];

  obbqt_pkg::slot_t  rec_q, srd_q, swd;
  obbqt_pkg::level_t lrd_q, lwd, best_q [2];
  logic              fail_q;
  logic [AW-1:0]     p_q, i_q, nx_q, steps_q, clr_q, swa, sra;
  logic              swe, sre, lwe, lre;
  logic [CW-1:0]     j_q, n;
  logic [CW-1:0]     cnt_q [2];
  logic [LW-1:0]     k_q, lwa_i, lra_i;
  logic [32:0]       qsum;
  logic [31:0]       qsat;
  obbqt_pkg::out_item_t out_q;
  logic              out_valid_q;

  assign n = cnt_q[rec_q.side];

  // slot table port
  always_comb begin
    swe = cmd_i.clr_wr | cmd_i.slot_wr_put | cmd_i.slot_wr_free_p | cmd_i.slot_wr_free_nx;
    swa = p_q;
    swd = rec_q;
    swd.used = 1'b1;
    if (cmd_i.clr_wr) begin
      swa = clr_q;
      swd = '0;
    end else if (cmd_i.slot_wr_free_p) begin
      swd = srd_q;
      swd.used = 1'b0;
    end else if (cmd_i.slot_wr_free_nx) begin
      swa = nx_q;
      swd = srd_q;
      swd.used = 1'b0;
    end
    sre = cmd_i.slot_rd_p | cmd_i.slot_rd_nx;
    sra = cmd_i.slot_rd_nx ? nx_q : p_q;
  end

  always_ff @(posedge clk_i) begin
    if (swe) slot_mem[swa] <= swd;
    if (sre) srd_q <= slot_mem[sra];
  end

  // level book port
  always_comb begin
    qsum = {1'b0, lrd_q.qty} + {1'b0, rec_q.qty};
    qsat = qsum[32] ? obbqt_pkg::QtyMax : qsum[31:0];
    lwe  = cmd_i.lvl_wr_merge | cmd_i.lvl_wr_reduce | cmd_i.lvl_wr_move | cmd_i.lvl_wr_ins;
    lwa_i = cmd_i.lvl_wr_move ? k_q : j_q[LW-1:0];
    lwd  = lrd_q;
    if (cmd_i.lvl_wr_merge)  lwd.qty = qsat;
    if (cmd_i.lvl_wr_reduce) lwd.qty = lrd_q.qty - rec_q.qty;
    if (cmd_i.lvl_wr_ins) begin
      lwd.price = rec_q.price;
      lwd.qty   = rec_q.qty;
    end
    lre   = cmd_i.lvl_rd_j | cmd_i.lvl_rd_km1 | cmd_i.lvl_rd_kp1;
    lra_i = j_q[LW-1:0];
    if (cmd_i.lvl_rd_km1) lra_i = k_q - LW'(1);
    if (cmd_i.lvl_rd_kp1) lra_i = k_q + LW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (lwe) lvl_mem[{rec_q.side, lwa_i}] <= lwd;
    if (lre) lrd_q <= lvl_mem[{rec_q.side, lra_i}];
    if (lwe && lwa_i == '0) best_q[rec_q.side] <= lwd;
  end

  // record, pointers and counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      rec_q.used  <= 1'b1;
      rec_q.key   <= in_item_i.ord_ref;
      rec_q.side  <= in_item_i.side;
      rec_q.price <= in_item_i.price;
      rec_q.qty   <= in_item_i.qty;
    end
    if (cmd_i.take_found) begin
      rec_q.side  <= srd_q.side;
      rec_q.price <= srd_q.price;
      rec_q.qty   <= srd_q.qty;
    end
    if (cmd_i.take_lift) rec_q <= srd_q;
    if (cmd_i.cap_in) begin
      p_q <= in_item_i.ord_ref[AW-1:0];
      i_q <= '0;
    end else if (cmd_i.probe_home) begin
      p_q <= rec_q.key[AW-1:0];
      i_q <= '0;
    end else if (cmd_i.probe_next) begin
      p_q <= p_q + AW'(1);
      i_q <= i_q + AW'(1);
    end
    if (cmd_i.nx_init) begin
      nx_q    <= p_q + AW'(1);
      steps_q <= '0;
    end else if (cmd_i.nx_next) begin
      nx_q    <= nx_q + AW'(1);
      steps_q <= steps_q + AW'(1);
    end
    if (cmd_i.lvl_init)      j_q <= '0;
    else if (cmd_i.lvl_next) j_q <= j_q + CW'(1);
    if (cmd_i.k_from_n)      k_q <= n[LW-1:0];
    else if (cmd_i.k_from_j) k_q <= j_q[LW-1:0];
    else if (cmd_i.k_dec)    k_q <= k_q - LW'(1);
    else if (cmd_i.k_inc)    k_q <= k_q + LW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      fail_q      <= 1'b0;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr)   clr_q  <= clr_q + AW'(1);
      if (cmd_i.cap_in)   fail_q <= 1'b0;
      if (cmd_i.set_fail) fail_q <= 1'b1;
      if (cmd_i.cnt_inc)  cnt_q[rec_q.side] <= n + CW'(1);
      if (cmd_i.cnt_dec)  cnt_q[rec_q.side] <= n - CW'(1);
      if (cmd_i.out_load)       out_valid_q <= 1'b1;
      else if (!out_stall_i)    out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status <= fail_q;
      out_q.bid_px <= (cnt_q[0] != '0) ? best_q[0].price : '0;
      out_q.bid_sz <= (cnt_q[0] != '0) ? best_q[0].qty   : '0;
      out_q.ask_px <= (cnt_q[1] != '0) ? best_q[1].price : '0;
      out_q.ask_sz <= (cnt_q[1] != '0) ? best_q[1].qty   : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    sts_o.mode       = in_item_i.mode;
    sts_o.used       = srd_q.used;
    sts_o.key_eq     = srd_q.key == rec_q.key;
    sts_o.probe_last = i_q == AW'(TABLE_SLOTS - 1);
    sts_o.steps_done = steps_q == AW'(TABLE_SLOTS - 1);
    sts_o.j_end      = j_q == n;
    sts_o.book_full  = n == CW'(BOOK_LEVELS);
    sts_o.lvl_eq     = lrd_q.price == rec_q.price;
    sts_o.lvl_better = rec_q.side ? ($signed(rec_q.price) < $signed(lrd_q.price))
                                  : ($signed(rec_q.price) > $signed(lrd_q.price));
    sts_o.lvl_le     = lrd_q.qty <= rec_q.qty;
    sts_o.k_at_j     = CW'(k_q) == j_q;
    sts_o.k_end      = (CW'(k_q) + CW'(1)) == n;
    sts_o.clr_last   = clr_q == '1;
    sts_o.out_busy   = out_valid_q & out_stall_i;
  end

endmodule

[rtl/core/obbqt_chk.sv]
// Port-level checker for the order book best-quote tracker, bound to the top level.
// Uses obbqt_pkg types.
module obbqt_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input obbqt_pkg::out_item_t out_item_o
);

  // item accepted -> busy next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after item accepted");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // a result only finishes while an item is in work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without item in work");

endmodule

bind order_book_best_quote_tracker_top obbqt_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
